>>> sv/bpu_pkg.sv
package bpu_pkg;

    // Pixel format codes
    localparam logic [1:0] FMT_GRAY8       = 2'd0;
    localparam logic [1:0] FMT_BGR24       = 2'd1;
    localparam logic [1:0] FMT_BITFIELD32  = 2'd2;

    // Register indexes on the configuration port
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_FORMAT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RED_MASK     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_GREEN_MASK   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BLUE_MASK    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_MASK   = 3'd6;

    // Reset values of the registers
    localparam logic [1:0]  RST_PIXEL_FORMAT = FMT_GRAY8;
    localparam logic [15:0] RST_IMAGE_WIDTH  = 16'd1;
    localparam logic [15:0] RST_IMAGE_HEIGHT = 16'd1;
    localparam logic [31:0] RST_RED_MASK     = 32'h00FF_0000;
    localparam logic [31:0] RST_GREEN_MASK   = 32'h0000_FF00;
    localparam logic [31:0] RST_BLUE_MASK    = 32'h0000_00FF;
    localparam logic [31:0] RST_ALPHA_MASK   = 32'hFF00_0000;

    // Mask size limits that pick the channel shift
    localparam logic [31:0] MASK_LIM_B0 = 32'h0000_00FF;
    localparam logic [31:0] MASK_LIM_B1 = 32'h0000_FF00;
    localparam logic [31:0] MASK_LIM_B2 = 32'h00FF_0000;

    localparam int unsigned ROW_BYTES_W = 18;

    // Bytes per pixel less one; unused code 3 behaves as gray
    function automatic logic [1:0] bpp_minus1(logic [1:0] fmt);
        logic [1:0] r;
        case (fmt)
            FMT_BGR24:      r = 2'd2;
            FMT_BITFIELD32: r = 2'd3;
            default:        r = 2'd0;
        endcase
        return r;
    endfunction

    // One channel of a 32-bit bitfield pixel
    function automatic logic [7:0] channel(logic [31:0] word, logic [31:0] mask);
        logic [31:0] masked;
        logic [7:0]  r;
        masked = word & mask;
        if (mask <= MASK_LIM_B0)
            r = masked[7:0];
        else if (mask <= MASK_LIM_B1)
            r = masked[15:8];
        else if (mask <= MASK_LIM_B2)
            r = masked[23:16];
        else
            r = masked[31:24];
        return r;
    endfunction

endpackage

>>> sv/bmp_pixel_unpacker.sv
// Output: registered; the result is on the port in the cycle after the input transfer of a pixel's last byte.
// Throughput: one byte per cycle; the result register is the only stage, and input is held
//   off only while that register is full and the sink is not taking it.
// Reset: rst_n asynchronous, active low; registers return to gray format, 1x1 image and the
//   default RGBA masks, and all row and pixel counters clear.
module bmp_pixel_unpacker
(
    input  logic        clk,
    input  logic        rst_n,

    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bpu_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [31:0]                         cfg_data,

    // byte stream in
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,

    // pixels out
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] pixel,
    output logic        row_end,
    output logic        image_end
);

    localparam int unsigned RBW = bpu_pkg::ROW_BYTES_W;

    // ------------------------------------------------------------------
    // Configuration registers; the port never stalls.
    // ------------------------------------------------------------------
    logic [1:0]  pixel_format_reg;
    logic [15:0] image_width_reg;
    logic [15:0] image_height_reg;
    logic [31:0] red_mask_reg;
    logic [31:0] green_mask_reg;
    logic [31:0] blue_mask_reg;
    logic [31:0] alpha_mask_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_format_reg <= bpu_pkg::RST_PIXEL_FORMAT;
            image_width_reg  <= bpu_pkg::RST_IMAGE_WIDTH;
            image_height_reg <= bpu_pkg::RST_IMAGE_HEIGHT;
            red_mask_reg     <= bpu_pkg::RST_RED_MASK;
            green_mask_reg   <= bpu_pkg::RST_GREEN_MASK;
            blue_mask_reg    <= bpu_pkg::RST_BLUE_MASK;
            alpha_mask_reg   <= bpu_pkg::RST_ALPHA_MASK;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bpu_pkg::REG_PIXEL_FORMAT: pixel_format_reg <= cfg_data[1:0];
                bpu_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[15:0];
                bpu_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[15:0];
                bpu_pkg::REG_RED_MASK:     red_mask_reg     <= cfg_data;
                bpu_pkg::REG_GREEN_MASK:   green_mask_reg   <= cfg_data;
                bpu_pkg::REG_BLUE_MASK:    blue_mask_reg    <= cfg_data;
                bpu_pkg::REG_ALPHA_MASK:   alpha_mask_reg   <= cfg_data;
                default: ; // writes past the register list are dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stream state
    // ------------------------------------------------------------------
    logic [1:0]     byte_in_pixel_reg,  byte_in_pixel_next;
    logic [23:0]    partial_pixel_reg,  partial_pixel_next;
    logic [RBW-1:0] row_byte_count_reg, row_byte_count_next;
    logic [15:0]    column_count_reg,   column_count_next;
    logic [15:0]    row_count_reg,      row_count_next;

    // Result register
    logic           out_valid_reg, out_valid_next;
    logic [31:0]    pixel_reg;
    logic           row_end_reg;
    logic           image_end_reg;

    logic           in_xfer;
    logic           emit;
    logic [31:0]    px;
    logic           rend;
    logic           iend;

    logic [1:0]     bpp_m1;
    logic [RBW-1:0] row_bytes;
    logic [RBW-1:0] stride;
    logic [15:0]    last_row;
    logic [31:0]    word;
    logic [16:0]    col_inc;

    // Input is taken whenever the result register is free or being drained.
    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    // Row stride: row bytes rounded up to a four-byte boundary. Fits 18 bits
    // for every width and format.
    always_comb
    begin
        bpp_m1 = bpu_pkg::bpp_minus1(pixel_format_reg);
        case (bpp_m1)
            2'd2:    row_bytes = {2'b00, image_width_reg} + {1'b0, image_width_reg, 1'b0};
            2'd3:    row_bytes = {image_width_reg, 2'b00};
            default: row_bytes = {2'b00, image_width_reg};
        endcase
        stride   = (row_bytes + RBW'(3)) & ~RBW'(3);
        last_row = image_height_reg - 16'd1;
    end

    // Pixel assembly and counter update for one byte
    always_comb
    begin
        word    = {data_byte, partial_pixel_reg};
        col_inc = {1'b0, column_count_reg} + 17'd1;

        case (bpp_m1)
            2'd0:    px = {24'd0, data_byte};
            2'd2:    px = {8'd0, partial_pixel_reg[7:0], partial_pixel_reg[15:8], data_byte};
            2'd3:    px = {bpu_pkg::channel(word, alpha_mask_reg),
                           bpu_pkg::channel(word, blue_mask_reg),
                           bpu_pkg::channel(word, green_mask_reg),
                           bpu_pkg::channel(word, red_mask_reg)};
            default: px = {24'd0, data_byte}; // not reachable; code 3 maps to gray
        endcase

        rend = (col_inc == {1'b0, image_width_reg});
        iend = rend && (row_count_reg == last_row);

        byte_in_pixel_next  = byte_in_pixel_reg;
        partial_pixel_next  = partial_pixel_reg;
        column_count_next   = column_count_reg;
        row_count_next      = row_count_reg;
        row_byte_count_next = row_byte_count_reg + RBW'(1);
        emit                = 1'b0;

        if (column_count_reg < image_width_reg)
        begin
            if (byte_in_pixel_reg >= bpp_m1)
            begin
                emit               = 1'b1;
                byte_in_pixel_next = 2'd0;
                partial_pixel_next = 24'd0;
                column_count_next  = col_inc[15:0];
            end
            else
            begin
                // byte_in_pixel is at most 2 here
                case (byte_in_pixel_reg)
                    2'd0:    partial_pixel_next = partial_pixel_reg | {16'd0, data_byte};
                    2'd1:    partial_pixel_next = partial_pixel_reg | {8'd0, data_byte, 8'd0};
                    default: partial_pixel_next = partial_pixel_reg | {data_byte, 16'd0};
                endcase
                byte_in_pixel_next = byte_in_pixel_reg + 2'd1;
            end
        end

        // End of row: all pixels out and the padding consumed
        if (column_count_next >= image_width_reg && row_byte_count_next >= stride)
        begin
            row_byte_count_next = '0;
            column_count_next   = 16'd0;
            byte_in_pixel_next  = 2'd0;
            partial_pixel_next  = 24'd0;
            if (row_count_reg == last_row)
                row_count_next = 16'd0;
            else
                row_count_next = row_count_reg + 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_in_pixel_reg  <= 2'd0;
            partial_pixel_reg  <= 24'd0;
            row_byte_count_reg <= '0;
            column_count_reg   <= 16'd0;
            row_count_reg      <= 16'd0;
        end
        else if (in_xfer)
        begin
            byte_in_pixel_reg  <= byte_in_pixel_next;
            partial_pixel_reg  <= partial_pixel_next;
            row_byte_count_reg <= row_byte_count_next;
            column_count_reg   <= column_count_next;
            row_count_reg      <= row_count_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register: loads on a completing byte, clears once taken.
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (in_xfer && emit)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && emit)
        begin
            pixel_reg     <= px;
            row_end_reg   <= rend;
            image_end_reg <= iend;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel     = pixel_reg;
    assign row_end   = row_end_reg;
    assign image_end = image_end_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_image_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!image_end_reg || row_end_reg))
        else $error("image end flagged without row end");

    a_emit_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && emit) |=> out_valid_reg)
        else $error("completed pixel not presented");

    a_gray_no_partial: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_format_reg == bpu_pkg::FMT_GRAY8 && byte_in_pixel_reg == 2'd0)
        |=> byte_in_pixel_reg == 2'd0)
        else $error("gray format collected a partial pixel");

endmodule

>>> bench/tb_bmp_pixel_unpacker.sv
`timescale 1ns / 100ps

module tb_bmp_pixel_unpacker;

    // Format code 3 has no name in the package; it should behave as gray
    localparam logic [1:0] FMT_UNUSED3 = 2'd3;

    // Generous bound on the length of the run
    localparam int unsigned CYCLE_LIMIT = 400_000;

    // ------------------------------------------------------------------
    // DUT connections
    // ------------------------------------------------------------------
    logic                            clk;
    logic                            rst_n;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [bpu_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [31:0]                     cfg_data;
    logic                            in_valid;
    logic                            in_ready;
    logic [7:0]                      data_byte;
    logic                            out_valid;
    logic                            out_ready;
    logic [31:0]                     pixel;
    logic                            row_end;
    logic                            image_end;

    bmp_pixel_unpacker DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel     (pixel),
        .row_end   (row_end),
        .image_end (image_end)
    );

    // ------------------------------------------------------------------
    // Clock and cycle guard
    // ------------------------------------------------------------------
    initial clk = 1'b0;
    always #5 clk = ~clk;

    int unsigned cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Decoder model: shadow registers and stream state
    // ------------------------------------------------------------------
    typedef struct packed
    {
        logic [31:0] pixel;
        logic        row_end;
        logic        image_end;
    } unpacked_px_t;

    // Pixels the DUT still owes us, oldest first
    unpacked_px_t expected_pixels[$];

    logic [1:0]  reg_fmt;
    logic [15:0] reg_width;
    logic [15:0] reg_height;
    logic [31:0] reg_red;
    logic [31:0] reg_green;
    logic [31:0] reg_blue;
    logic [31:0] reg_alpha;

    logic [1:0]  bip_q;        // next byte index within the pixel
    logic [23:0] partial_q;    // bytes of the pixel so far, byte k at 8k
    logic [17:0] row_bytes_q;  // bytes consumed in this row, padding included
    logic [15:0] col_q;        // pixels out in this row
    logic [15:0] row_q;        // rows finished in this image

    int unsigned mismatch_count = 0;
    int unsigned bytes_sent     = 0;

    // Idling controls for the stimulus (gaps_on) and the sink (stalls_on, hold_req)
    bit          gaps_on   = 1'b1;
    bit          stalls_on = 1'b1;
    int unsigned hold_req  = 0;

    function automatic int unsigned bytes_per_px(logic [1:0] fmt);
        case (fmt)
            bpu_pkg::FMT_BGR24:      return 3;
            bpu_pkg::FMT_BITFIELD32: return 4;
            default:                 return 1;
        endcase
    endfunction

    // Row length in bytes, rounded up to a four-byte boundary
    function automatic int unsigned row_stride();
        return (32'(reg_width) * bytes_per_px(reg_fmt) + 32'd3) & ~32'd3;
    endfunction

    // Mask the word, then drop it by the byte lane the mask reaches into
    function automatic logic [7:0] extract_field(logic [31:0] word, logic [31:0] m);
        logic [31:0] sel;
        int unsigned sh;
        sel = word & m;
        if (m <= bpu_pkg::MASK_LIM_B0)
            sh = 0;
        else if (m <= bpu_pkg::MASK_LIM_B1)
            sh = 8;
        else if (m <= bpu_pkg::MASK_LIM_B2)
            sh = 16;
        else
            sh = 24;
        return 8'(sel >> sh);
    endfunction

    function automatic void apply_reg_write(logic [bpu_pkg::CFG_INDEX_W-1:0] i,
                                            logic [31:0] v);
        case (i)
            bpu_pkg::REG_PIXEL_FORMAT: reg_fmt    = v[1:0];
            bpu_pkg::REG_IMAGE_WIDTH:  reg_width  = v[15:0];
            bpu_pkg::REG_IMAGE_HEIGHT: reg_height = v[15:0];
            bpu_pkg::REG_RED_MASK:     reg_red    = v;
            bpu_pkg::REG_GREEN_MASK:   reg_green  = v;
            bpu_pkg::REG_BLUE_MASK:    reg_blue   = v;
            bpu_pkg::REG_ALPHA_MASK:   reg_alpha  = v;
            default:                   ;
        endcase
    endfunction

    // Advance the model by one accepted byte; queue a pixel if one completes.
    // Counters survive register changes, so the column, byte and stride bounds
    // are compared with < or >= rather than ==, exactly as the hardware does it.
    function automatic void step_model(logic [7:0] b);
        int unsigned  bpp;
        int unsigned  stride;
        logic [15:0]  last_row;
        logic [31:0]  word;
        logic [31:0]  px;
        unpacked_px_t e;
        bpp      = bytes_per_px(reg_fmt);
        stride   = row_stride();
        last_row = reg_height - 16'd1;   // height 0 wraps to row 0xFFFF

        row_bytes_q = row_bytes_q + 18'd1;

        if (col_q < reg_width)
        begin
            if (32'(bip_q) + 32'd1 >= bpp)
            begin
                if (bpp == 1)
                    px = {24'h0, b};
                else if (bpp == 3)
                    px = {8'h00, partial_q[7:0], partial_q[15:8], b};   // BGR -> RGB
                else
                begin
                    word = {b, partial_q};                               // little endian
                    px   = {extract_field(word, reg_alpha), extract_field(word, reg_blue),
                            extract_field(word, reg_green), extract_field(word, reg_red)};
                end
                e.pixel     = px;
                e.row_end   = (17'(col_q) + 17'd1) == 17'(reg_width);
                e.image_end = e.row_end && (row_q == last_row);
                expected_pixels.push_back(e);
                bip_q     = 2'd0;
                partial_q = 24'h0;
                col_q     = col_q + 16'd1;
            end
            else
            begin
                partial_q = 24'(32'(partial_q) | (32'(b) << (8 * bip_q)));
                bip_q     = bip_q + 2'd1;
            end
        end
        // otherwise the byte is padding and only counts towards the stride

        if (col_q >= reg_width && 32'(row_bytes_q) >= stride)
        begin
            row_bytes_q = 18'h0;
            col_q       = 16'h0;
            bip_q       = 2'd0;
            partial_q   = 24'h0;
            row_q       = (row_q == last_row) ? 16'h0 : row_q + 16'd1;
        end
    endfunction

    function automatic bit at_image_start();
        return row_q == 16'h0 && col_q == 16'h0 && row_bytes_q == 18'h0 && bip_q == 2'd0;
    endfunction

    // ------------------------------------------------------------------
    // Pixel sink: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : sink_driver
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                out_ready <= 1'b0;
            else if (hold_req != 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_req) @(posedge clk);
                hold_req = 0;
                out_ready <= 1'b1;
            end
            else if (stalls_on && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every pixel transfer against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_pixels
        unpacked_px_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("unexpected pixel %h row_end %b image_end %b at cycle %0d",
                             pixel, row_end, image_end, cycle_count);
                mismatch_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (pixel !== want.pixel || row_end !== want.row_end ||
                    image_end !== want.image_end)
                begin
                    if (mismatch_count < 10)
                        $display("pixel mismatch at cycle %0d: exp %h/%b/%b got %h/%b/%b",
                                 cycle_count, want.pixel, want.row_end, want.image_end,
                                 pixel, row_end, image_end);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // One byte transfer. in_valid is left high afterwards so back-to-back
    // bytes never see a low-high pair in the same step; a gap lowers it.
    task automatic send_byte(input logic [7:0] b);
        if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        step_model(b);
        bytes_sent++;
    endtask

    // Stop offering bytes and wait until every predicted pixel has arrived,
    // then let padding bytes still in flight drain
    task automatic finish_stream();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all seven registers; only called with the block idle
    task automatic program_regs(input logic [1:0] fmt, input logic [15:0] w, input logic [15:0] h,
                                input logic [31:0] rm, input logic [31:0] gm,
                                input logic [31:0] bm, input logic [31:0] am);
        logic [bpu_pkg::CFG_INDEX_W-1:0] idx [7];
        logic [31:0]                     val [7];
        idx[0] = bpu_pkg::REG_PIXEL_FORMAT;  val[0] = {30'h0, fmt};
        idx[1] = bpu_pkg::REG_IMAGE_WIDTH;   val[1] = {16'h0, w};
        idx[2] = bpu_pkg::REG_IMAGE_HEIGHT;  val[2] = {16'h0, h};
        idx[3] = bpu_pkg::REG_RED_MASK;      val[3] = rm;
        idx[4] = bpu_pkg::REG_GREEN_MASK;    val[4] = gm;
        idx[5] = bpu_pkg::REG_BLUE_MASK;     val[5] = bm;
        idx[6] = bpu_pkg::REG_ALPHA_MASK;    val[6] = am;
        for (int i = 0; i < 7; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            apply_reg_write(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic program_defaults(input logic [1:0] fmt, input logic [15:0] w,
                                    input logic [15:0] h);
        program_regs(fmt, w, h, bpu_pkg::RST_RED_MASK, bpu_pkg::RST_GREEN_MASK,
                     bpu_pkg::RST_BLUE_MASK, bpu_pkg::RST_ALPHA_MASK);
    endtask

    // Masks biased to the lane boundaries that decide the shift
    function automatic logic [31:0] pick_mask();
        case ($urandom_range(0, 11))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h0000_00FF;
            3:       return 32'h0000_0100;
            4:       return 32'h0000_FF00;
            5:       return 32'h0000_FF01;
            6:       return 32'h00FF_0000;
            7:       return 32'h00FF_0001;
            8:       return 32'h8000_0000;
            default: return $urandom();
        endcase
    endfunction

    task automatic program_random();
        logic [1:0]  fmt;
        logic [15:0] w;
        logic [15:0] h;
        int unsigned pick;
        pick = $urandom_range(0, 15);
        if (pick < 5)
            fmt = bpu_pkg::FMT_GRAY8;
        else if (pick < 10)
            fmt = bpu_pkg::FMT_BGR24;
        else if (pick < 15)
            fmt = bpu_pkg::FMT_BITFIELD32;
        else
            fmt = FMT_UNUSED3;
        // mostly narrow images, now and then a wider one
        w = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(7, 40)) : 16'($urandom_range(1, 6));
        h = 16'($urandom_range(1, 3));
        if ($urandom_range(0, 2) == 0)
            program_defaults(fmt, w, h);
        else
            program_regs(fmt, w, h, pick_mask(), pick_mask(), pick_mask(), pick_mask());
    endtask

    // One whole image under the current registers, padding with random values
    task automatic send_image();
        int unsigned bpp;
        int unsigned stride;
        bpp    = bytes_per_px(reg_fmt);
        stride = row_stride();
        for (int unsigned r = 0; r < reg_height; r++)
        begin
            for (int unsigned k = 0; k < 32'(reg_width) * bpp; k++)
                send_byte(8'($urandom_range(0, 255)));
            for (int unsigned k = 32'(reg_width) * bpp; k < stride; k++)
                send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // After a broken sequence the counters sit mid-image. Make the current
    // row the last one (and the width sane), then feed bytes until the row
    // closes, so later images line up again. Doubles as a mid-stream
    // register change.
    task automatic align_to_image_start();
        logic [15:0] w;
        if (!at_image_start())
        begin
            w = (reg_width == 16'h0 || reg_width > 16'd64) ? 16'd4 : reg_width;
            program_regs(reg_fmt, w, row_q + 16'd1, reg_red, reg_green, reg_blue, reg_alpha);
            while (!at_image_start())
                send_byte(8'($urandom_range(0, 255)));
            finish_stream();
        end
    endtask

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Registers as they come out of reset: gray, 1x1, one pixel and 3 pad bytes
    task automatic test_reset_values();
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h55);
        send_byte(8'hAA);
        finish_stream();
    endtask

    // Gray pass-through with byte extremes; padding is non-zero and ignored
    task automatic test_gray_extremes();
        program_defaults(bpu_pkg::FMT_GRAY8, 16'd3, 16'd1);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h7E);
        finish_stream();
    endtask

    // B,G,R in the file must come out as R,G,B
    task automatic test_bgr_order();
        program_defaults(bpu_pkg::FMT_BGR24, 16'd1, 16'd1);
        send_byte(8'h11);
        send_byte(8'h22);
        send_byte(8'h33);
        send_byte(8'hFF);
        finish_stream();
    endtask

    // Bitfield mode with full, empty and off-lane masks
    task automatic test_bitfield_masks();
        program_regs(bpu_pkg::FMT_BITFIELD32, 16'd1, 16'd1,
                     32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0100, 32'h00FF_0001);
        send_byte(8'hA5);
        send_byte(8'h3C);
        send_byte(8'hFF);
        send_byte(8'h81);
        finish_stream();
    endtask

    // Unused format code decodes as gray
    task automatic test_unused_format();
        program_defaults(FMT_UNUSED3, 16'd2, 16'd1);
        send_byte(8'h01);
        send_byte(8'hFE);
        send_byte(8'h00);
        send_byte(8'h00);
        finish_stream();
    endtask

    // Zero width: every byte closes an empty row, nothing comes out
    task automatic test_zero_width();
        program_defaults(bpu_pkg::FMT_GRAY8, 16'd0, 16'd1);
        send_byte(8'h12);
        send_byte(8'h34);
        finish_stream();
    endtask

    // Zero height: the last row would be 0xFFFF, so row 0 gives no image end
    task automatic test_zero_height();
        program_defaults(bpu_pkg::FMT_GRAY8, 16'd1, 16'd0);
        send_byte(8'h9C);
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'h03);
        finish_stream();
        align_to_image_start();
    endtask

    // Largest width and height; only the start of the first row is sent
    task automatic test_large_dims();
        program_defaults(bpu_pkg::FMT_GRAY8, 16'hFFFF, 16'hFFFF);
        send_byte(8'hC0);
        send_byte(8'h3F);
        send_byte(8'hE7);
        finish_stream();
        align_to_image_start();
    endtask

    // ------------------------------------------------------------------
    // Random and stress tests
    // ------------------------------------------------------------------

    // Mostly whole images, sometimes back to back under the same registers,
    // with the odd burst of stray bytes that breaks the framing
    task automatic test_random_images(input int unsigned byte_budget);
        int unsigned stop_at;
        bit          reprogram;
        stop_at   = bytes_sent + byte_budget;
        reprogram = 1'b1;
        while (bytes_sent < stop_at)
        begin
            if (reprogram || $urandom_range(0, 1) == 0)
            begin
                finish_stream();
                program_random();
            end
            reprogram = 1'b0;
            send_image();
            if ($urandom_range(0, 7) == 0)
            begin
                repeat ($urandom_range(1, 7)) send_byte(8'($urandom_range(0, 255)));
                finish_stream();
                align_to_image_start();
                reprogram = 1'b1;
            end
        end
        finish_stream();
    endtask

    // Sink holds off for a long stretch while bytes keep coming, so the
    // output register fills and the input side has to back up
    task automatic test_output_hold();
        gaps_on = 1'b0;
        program_defaults(bpu_pkg::FMT_GRAY8, 16'd24, 16'd1);
        hold_req = 150;
        send_image();
        finish_stream();
        gaps_on = 1'b1;
    endtask

    // Closing stretch at full rate on both sides
    task automatic test_full_rate();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        test_random_images(120);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = bpu_pkg::REG_PIXEL_FORMAT;
        cfg_data  = 32'h0;
        in_valid  = 1'b0;
        data_byte = 8'h00;

        reg_fmt     = bpu_pkg::RST_PIXEL_FORMAT;
        reg_width   = bpu_pkg::RST_IMAGE_WIDTH;
        reg_height  = bpu_pkg::RST_IMAGE_HEIGHT;
        reg_red     = bpu_pkg::RST_RED_MASK;
        reg_green   = bpu_pkg::RST_GREEN_MASK;
        reg_blue    = bpu_pkg::RST_BLUE_MASK;
        reg_alpha   = bpu_pkg::RST_ALPHA_MASK;
        bip_q       = 2'd0;
        partial_q   = 24'h0;
        row_bytes_q = 18'h0;
        col_q       = 16'h0;
        row_q       = 16'h0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_gray_extremes();
        test_bgr_order();
        test_bitfield_masks();
        test_unused_format();
        test_zero_width();
        test_zero_height();
        test_large_dims();
        test_random_images(600);
        test_output_hold();
        test_full_rate();

        finish_stream();
        if (expected_pixels.size() != 0)
            mismatch_count++;

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
